// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the divider RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define FSUD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define FSUD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSUD_ASSERT(label, clk, rst_n, prop, msg)
`define FSUD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/fsud_pkg.sv =====
// Package for the four-state unsigned divider: widths, masks and the stage payload type.
// Depends on nothing; used by the interfaces, the cell and the top level.
package fsud_pkg;

    // Width of every port field.
    localparam int FIELD_W = 32;

    // Operand and result widths taking part in the division.
    localparam int DIVIDEND_WIDTH = 32;
    localparam int DIVISOR_WIDTH  = 32;
    localparam int QUOTIENT_WIDTH = 32;

    // Effective widths, capped at the port field width.
    localparam int DVD_W = (DIVIDEND_WIDTH < FIELD_W) ? DIVIDEND_WIDTH : FIELD_W;
    localparam int DVS_W = (DIVISOR_WIDTH < FIELD_W) ? DIVISOR_WIDTH : FIELD_W;
    localparam int QUO_W = (QUOTIENT_WIDTH < FIELD_W) ? QUOTIENT_WIDTH : FIELD_W;

    // One cell per dividend bit.
    localparam int NUM_CELLS = DVD_W;

    // Mask that keeps the low QUO_W bits of a quotient field.
    localparam logic [FIELD_W-1:0] QUO_MASK = FIELD_W'((64'd1 << QUO_W) - 64'd1);

    // Payload carried from cell to cell.
    // work holds the unconsumed dividend bits in its top and the quotient bits
    // developed so far in its bottom.
    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [DVD_W-1:0] work;
        logic [DVS_W-1:0] divisor;
        logic             unknown;
    } stage_t;

endpackage

// ===== hdl/fsud_in_if.sv =====
// Operand channel of the divider: valid/ready handshake with four-state operands.
// Depends on fsud_pkg for the field width.
interface fsud_in_if
    import fsud_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] dividend_unknown;
    logic [FIELD_W-1:0] divisor;
    logic [FIELD_W-1:0] divisor_unknown;

    modport source (
        output valid, dividend, dividend_unknown, divisor, divisor_unknown,
        input  ready
    );

    modport sink (
        input  valid, dividend, dividend_unknown, divisor, divisor_unknown,
        output ready
    );
endinterface

// ===== hdl/fsud_out_if.sv =====
// Result channel of the divider: valid/ready handshake with quotient and unknown flag.
// Depends on fsud_pkg for the field width.
interface fsud_out_if
    import fsud_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] quotient;
    logic               result_unknown;

    modport source (
        output valid, quotient, result_unknown,
        input  ready
    );

    modport sink (
        input  valid, quotient, result_unknown,
        output ready
    );
endinterface

// ===== hdl/four_state_unsigned_divider.sv =====
// Four-state unsigned divider: top level, a chain of restoring-division cells.
// Depends on fsud_pkg, fsud_in_if, fsud_out_if, fsud_cell and assert_macros.svh.

// The divider accepts one operand item per clock cycle unless the chain is
// stalled, and passes each item through one cell per dividend bit, each
// producing one quotient bit; the last cell serves as the output register.
// A stall on the result channel freezes the whole chain, so the operand
// channel is ready whenever the last cell is empty or its item is being taken.
// Any unknown operand bit, or a zero divisor, gives result_unknown set and a
// zero quotient.
`include "assert_macros.svh"

module four_state_unsigned_divider
    import fsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fsud_in_if.sink    operands,
    fsud_out_if.source result
);

    logic   en;
    logic   cell_valid [0:NUM_CELLS];
    stage_t cell_stage [0:NUM_CELLS];
    stage_t first_stage;

    // The chain moves unless a finished item waits at the output.
    assign en             = !cell_valid[NUM_CELLS] || result.ready;
    assign operands.ready = en;

    // Mask operands to their widths and decide whether the result is unknown.
    always_comb
    begin
        first_stage.rem     = '0;
        first_stage.work    = operands.dividend[DVD_W-1:0];
        first_stage.divisor = operands.divisor[DVS_W-1:0];
        first_stage.unknown = (|operands.dividend_unknown[DVD_W-1:0])
                            || (|operands.divisor_unknown[DVS_W-1:0])
                            || (operands.divisor[DVS_W-1:0] == '0);
    end

    assign cell_valid[0] = operands.valid;
    assign cell_stage[0] = first_stage;

    // Row of division cells, one quotient bit each.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        fsud_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cell_valid[i]),
            .stage_in  (cell_stage[i]),
            .valid_out (cell_valid[i+1]),
            .stage_out (cell_stage[i+1])
        );
    end

    // Result item taken from the last cell.
    assign result.valid          = cell_valid[NUM_CELLS];
    assign result.result_unknown = cell_stage[NUM_CELLS].unknown;
    assign result.quotient       = cell_stage[NUM_CELLS].unknown ? '0
                                 : (FIELD_W'(cell_stage[NUM_CELLS].work) & QUO_MASK);

    // An accepted item occupies the first cell at the next edge.
    `FSUD_ASSERT(a_accept_fills_first, clk, rst_n,
        (operands.valid && operands.ready) |=> cell_valid[1],
        "divider: accepted item missing from the first cell")
    // A zero divisor marks the item unknown as soon as it enters the chain.
    `FSUD_ASSERT(a_zero_divisor_unknown, clk, rst_n,
        (operands.valid && operands.ready && (operands.divisor[DVS_W-1:0] == '0))
            |=> cell_stage[1].unknown,
        "divider: zero divisor not flagged unknown")
    // Nothing is accepted while a finished item is held back.
    `FSUD_ASSERT(a_no_accept_on_stall, clk, rst_n,
        (result.valid && !result.ready) |-> !operands.ready,
        "divider: operand accepted while the output is stalled")

endmodule

// ===== hdl/fsud_cell.sv =====
// One cell of the divider chain: a single restoring compare-and-subtract step.
// Depends on fsud_pkg for stage_t and on assert_macros.svh.
`include "assert_macros.svh"

module fsud_cell
    import fsud_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   valid_in,
    input  stage_t stage_in,
    output logic   valid_out,
    output stage_t stage_out
);

    logic         valid_reg;
    logic         valid_next;
    stage_t       stage_reg;
    stage_t       stage_next;
    logic [DVS_W:0] trial;
    logic [DVS_W:0] divisor_ext;
    logic           fits;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    always_comb
    begin
        trial       = {stage_in.rem, stage_in.work[DVD_W-1]};
        divisor_ext = {1'b0, stage_in.divisor};
        fits        = (trial >= divisor_ext);

        stage_next         = stage_in;
        stage_next.rem     = fits ? DVS_W'(trial - divisor_ext) : trial[DVS_W-1:0];
        stage_next.work    = {stage_in.work[DVD_W-2:0], fits};
        valid_next         = valid_in;
    end

    // Valid bit of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the cell; no reset needed.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

    // The partial remainder of a known division stays below the divisor.
    `FSUD_ASSERT(a_rem_below_divisor, clk, rst_n,
        (valid_reg && !stage_reg.unknown) |-> (stage_reg.rem < stage_reg.divisor),
        "fsud_cell: partial remainder not below divisor")
    // An item entering an enabled cell is held there at the next edge.
    `FSUD_ASSERT(a_valid_moves, clk, rst_n,
        (en && valid_in) |=> valid_reg,
        "fsud_cell: item lost on the way into the cell")
    // A stalled cell keeps its contents.
    `FSUD_ASSERT(a_stall_holds, clk, rst_n,
        !en |=> ($stable(valid_reg) && $stable(stage_reg)),
        "fsud_cell: cell changed while stalled")

endmodule
